FILE: hdl/stat_pkg.sv
// ----------------------------------------------------------------------------
// Section table address translator package
// Shared types and constants for the section table address translator.
// ----------------------------------------------------------------------------
package stat_pkg;

	// Number of section slots in the table.
	localparam int MAX_SECTIONS = 32;
	// Bits needed to address one slot.
	localparam int SEC_IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	// Bits needed to hold a slot count from zero up to MAX_SECTIONS.
	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
	// Width used to compare counts and indexes against MAX_SECTIONS.
	localparam int CMP_W = 7;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_UNMAPPED = 2'd1,
		STATUS_PAST_END = 2'd2
	} status_t;

	// Request types.
	typedef enum logic {
		REQ_WRITE     = 1'b0,
		REQ_TRANSLATE = 1'b1
	} req_kind_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_HEADER_SIZE   = 2'd0,
		CFG_FILE_SIZE     = 2'd1,
		CFG_SECTION_COUNT = 2'd2
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_PREP,
		S_HEADER,
		S_SCAN,
		S_CHK1,
		S_CHK2,
		S_CHK3,
		S_CHK4,
		S_DONE
	} state_t;

	// One stored section entry; the virtual end is kept precomputed.
	typedef struct packed {
		logic [31:0] virt_start;
		logic [32:0] virt_end;
		logic [31:0] raw_offset;
		logic [31:0] raw_len;
	} entry_t;

endpackage

FILE: hdl/stat_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying section writes and translate requests.
// ----------------------------------------------------------------------------
interface stat_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [4:0]  entry_index;
	logic [31:0] virt_start;
	logic [31:0] virt_size;
	logic [31:0] raw_offset;
	logic [31:0] raw_len;
	logic [31:0] query_addr;
	logic [31:0] query_len;

	modport source (
		output valid, req_type, entry_index, virt_start, virt_size,
		output raw_offset, raw_len, query_addr, query_len,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_index, virt_start, virt_size,
		input  raw_offset, raw_len, query_addr, query_len,
		output ready
	);
endinterface

FILE: hdl/stat_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the status and file offset of each request.
// ----------------------------------------------------------------------------
interface stat_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] file_offset;

	modport source (output valid, status, file_offset, input ready);
	modport sink (input valid, status, file_offset, output ready);
endinterface

FILE: hdl/stat_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready register write channel carrying a register index and data.
// ----------------------------------------------------------------------------
interface stat_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/section_table_address_translator.sv
// ----------------------------------------------------------------------------
// Section table address translator
// Stores executable-image section entries and maps relative virtual
// addresses to file offsets.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries two kinds of request. A write stores one section
// entry and returns status OK, or PAST_END when its raw range passes the
// file size, or UNMAPPED when the slot is outside the table. A translate
// returns the file offset of query_addr when query_len bytes are present.
// Every request gives exactly one transfer on the rsp channel, in order.
// The cfg channel writes header_size, file_size and section_count and is always
// ready; the user must write it only while no request is in flight, as the block
// does not enforce this. One request is worked on at a time; req is ready only
// while idle. A write passes through the WRITE and DONE states, and a translate
// through PREP and HEADER. A section translate then scans the table one entry per
// cycle through the single read port of the section memory and checks a hit in
// the CHK1 to CHK4 states before DONE; a miss of every slot ends after the scan.
// A registered response stage holds a result while the receiver stalls; the
// next request is still accepted, and the sequencer waits in its last state
// only if a new result is ready before the held one is taken.
// Reset clears the configuration registers, the sequencer and the response
// stage; the section memory is not cleared and must be written before it is searched.
// ----------------------------------------------------------------------------
module section_table_address_translator (
	input  logic          clk,
	input  logic          arst_n,
	stat_req_if.sink      req,
	stat_rsp_if.source    rsp,
	stat_cfg_if.sink      cfg
);
	import stat_pkg::*;

	// Configuration registers.
	logic [31:0] header_size_q;
	logic [31:0] file_size_q;
	logic [5:0]  section_count_q;

	// Sequencer.
	state_t state_q;
	state_t state_d;

	// Captured request.
	logic        req_type_q;
	logic [4:0]  entry_index_q;
	logic [31:0] virt_start_q;
	logic [31:0] virt_size_q;
	logic [31:0] raw_offset_q;
	logic [31:0] raw_len_q;
	logic [31:0] query_addr_q;
	logic [31:0] query_len_q;

	// Working registers.
	logic [32:0] query_end_q;
	logic        hdr_hit_q;
	entry_t      hit_ent_q;
	logic [31:0] within_q;
	logic [32:0] within_len_q;
	logic [32:0] raw_pos_q;
	logic        short_q;
	logic [33:0] total_q;
	status_t     res_status_q;
	logic [31:0] res_offset_q;

	// Section memory and its scan pipeline.
	entry_t              mem [MAX_SECTIONS];
	entry_t              rd_data_s1;
	logic                rd_vld_s1;
	logic [CNT_W-1:0]    rd_tag_s1;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                rd_en;

	// Response stage.
	logic        out_valid_q;
	status_t     out_status_q;
	logic [31:0] out_offset_q;

	// Derived control values.
	logic             req_fire;
	logic             rsp_load;
	logic [CNT_W-1:0] n_eff;
	logic             slot_ok;
	logic [31:0]      eff_vsize;
	logic [32:0]      new_vend;
	logic             new_past_end;
	logic             scan_hit;
	logic             scan_last;
	entry_t           new_ent;

	// Section count limited to the table size.
	always_comb begin
		if (CMP_W'(section_count_q) > CMP_W'(MAX_SECTIONS)) begin
			n_eff = CNT_W'(MAX_SECTIONS);
		end else begin
			n_eff = CNT_W'(section_count_q);
		end
	end

	// Write path: effective virtual size, virtual end and file bound check.
	always_comb begin
		slot_ok      = CMP_W'(entry_index_q) < CMP_W'(MAX_SECTIONS);
		eff_vsize    = (virt_size_q != 32'd0) ? virt_size_q : raw_len_q;
		new_vend     = {1'b0, virt_start_q} + {1'b0, eff_vsize};
		new_past_end = ({1'b0, raw_offset_q} + {1'b0, raw_len_q}) > {1'b0, file_size_q};
		new_ent.virt_start = virt_start_q;
		new_ent.virt_end   = new_vend;
		new_ent.raw_offset = raw_offset_q;
		new_ent.raw_len    = raw_len_q;
	end

	// Scan compare on the entry read in the previous cycle.
	always_comb begin
		scan_hit  = rd_vld_s1 && (query_addr_q >= rd_data_s1.virt_start)
			&& (query_end_q <= rd_data_s1.virt_end);
		scan_last = rd_vld_s1 && (({1'b0, rd_tag_s1} + 1'b1) == {1'b0, n_eff});
		rd_en     = (state_q == S_SCAN) && (rd_idx_q < n_eff) && !scan_hit;
	end

	assign req_fire = req.valid && req.ready;
	assign rsp_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Next state and handshake outputs.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (req_kind_t'(req.req_type) == REQ_WRITE) ? S_WRITE : S_PREP;
				end
			end
			S_WRITE:  state_d = S_DONE;
			S_PREP:   state_d = S_HEADER;
			S_HEADER: begin
				if (hdr_hit_q || (n_eff == '0)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					state_d = S_CHK1;
				end else if (scan_last) begin
					state_d = S_DONE;
				end
			end
			S_CHK1: state_d = S_CHK2;
			S_CHK2: state_d = S_CHK3;
			S_CHK3: state_d = S_CHK4;
			S_CHK4: state_d = S_DONE;
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers; writes beyond the register list are dropped.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_size_q   <= '0;
			file_size_q     <= '0;
			section_count_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_HEADER_SIZE:   header_size_q   <= cfg.data;
				CFG_FILE_SIZE:     file_size_q     <= cfg.data;
				CFG_SECTION_COUNT: section_count_q <= cfg.data[5:0];
				default: ;
			endcase
		end
	end

	// Request capture on each accepted transfer.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_type_q    <= req.req_type;
			entry_index_q <= req.entry_index;
			virt_start_q  <= req.virt_start;
			virt_size_q   <= req.virt_size;
			raw_offset_q  <= req.raw_offset;
			raw_len_q     <= req.raw_len;
			query_addr_q  <= req.query_addr;
			query_len_q   <= req.query_len;
		end
	end

	// Section memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if ((state_q == S_WRITE) && slot_ok) begin
			mem[SEC_IDX_W'(entry_index_q)] <= new_ent;
		end
		rd_data_s1 <= mem[rd_idx_q[SEC_IDX_W-1:0]];
		rd_tag_s1  <= rd_idx_q;
	end

	// Scan address counter and read valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (state_q == S_HEADER) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Translate and write datapath, one step per state.
	always_ff @(posedge clk) begin
		case (state_q)
			S_WRITE: begin
				res_offset_q <= '0;
				if (!slot_ok) begin
					res_status_q <= STATUS_UNMAPPED;
				end else if (new_past_end) begin
					res_status_q <= STATUS_PAST_END;
				end else begin
					res_status_q <= STATUS_OK;
				end
			end
			S_PREP: begin
				query_end_q <= {1'b0, query_addr_q} + {1'b0, query_len_q};
				hdr_hit_q   <= query_addr_q < header_size_q;
			end
			S_HEADER: begin
				res_status_q <= STATUS_UNMAPPED;
				res_offset_q <= '0;
				if (hdr_hit_q && (query_end_q <= {1'b0, header_size_q})
					&& (query_end_q <= {1'b0, file_size_q})) begin
					res_status_q <= STATUS_OK;
					res_offset_q <= query_addr_q;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					hit_ent_q <= rd_data_s1;
				end
			end
			S_CHK1: begin
				within_q <= query_addr_q - hit_ent_q.virt_start;
			end
			S_CHK2: begin
				within_len_q <= {1'b0, within_q} + {1'b0, query_len_q};
				raw_pos_q    <= {1'b0, hit_ent_q.raw_offset} + {1'b0, within_q};
				short_q      <= within_q >= hit_ent_q.raw_len;
			end
			S_CHK3: begin
				total_q <= {1'b0, raw_pos_q} + {2'b00, query_len_q};
				short_q <= short_q || (within_len_q > {1'b0, hit_ent_q.raw_len});
			end
			S_CHK4: begin
				if (short_q || (total_q > {2'b00, file_size_q})) begin
					res_status_q <= STATUS_UNMAPPED;
					res_offset_q <= '0;
				end else begin
					res_status_q <= STATUS_OK;
					res_offset_q <= raw_pos_q[31:0];
				end
			end
			default: ;
		endcase
	end

	// Response stage: loaded from the sequencer, emptied by a rsp transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_status_q <= res_status_q;
			out_offset_q <= (req_kind_t'(req_type_q) == REQ_WRITE) ? 32'd0 : res_offset_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.file_offset = out_offset_q;

endmodule

FILE: tb/xlat_tb_pkg.sv
// ----------------------------------------------------------------------------
// Section table translator scoreboard
// Request and result records, plus a scoreboard that predicts the status and
// file offset of every accepted request and checks the responses in order.
// ----------------------------------------------------------------------------
package xlat_tb_pkg;
	import stat_pkg::*;

	// One request as offered on the request channel.
	typedef struct {
		req_kind_t   kind;
		logic [4:0]  slot;
		logic [31:0] virt_start;
		logic [31:0] virt_size;
		logic [31:0] raw_offset;
		logic [31:0] raw_len;
		logic [31:0] query_addr;
		logic [31:0] query_len;
	} xlat_req_t;

	// One expected response.
	typedef struct {
		status_t     status;
		logic [31:0] file_offset;
	} xlat_result_t;

	class xlat_scoreboard;
		// Shadow copy of the registers and the section table.
		bit [31:0]      header_size;
		bit [31:0]      file_size;
		bit [5:0]       section_count;
		bit [31:0]      sec_start[MAX_SECTIONS];
		bit [31:0]      sec_span[MAX_SECTIONS];
		bit [31:0]      sec_offset[MAX_SECTIONS];
		bit [31:0]      sec_length[MAX_SECTIONS];
		xlat_result_t   pending_results[$];
		int unsigned    mismatches;
		int unsigned    writes_done;
		int unsigned    translates_done;
		int unsigned    status_seen[3];

		function void set_register(cfg_reg_t idx, logic [31:0] data);
			case (idx)
				CFG_HEADER_SIZE: header_size = data;
				CFG_FILE_SIZE: file_size = data;
				CFG_SECTION_COUNT: section_count = data[5:0];
				default: ;
			endcase
		endfunction

		// Updates the table for a section write, or maps the address of a
		// translate, and queues the response that the block must give.
		function void note_request(xlat_req_t r);
			xlat_result_t res;
			bit [63:0]    a;
			bit [63:0]    l;
			bit [63:0]    base;
			bit [63:0]    sec_pos;
			int           n;
			bit           hit;
			res.status = STATUS_OK;
			res.file_offset = '0;
			if (r.kind == REQ_WRITE) begin
				writes_done++;
				if (int'(r.slot) >= MAX_SECTIONS) begin
					res.status = STATUS_UNMAPPED;
				end else begin
					sec_start[r.slot] = r.virt_start;
					sec_span[r.slot] = (r.virt_size != 0) ? r.virt_size : r.raw_len;
					sec_offset[r.slot] = r.raw_offset;
					sec_length[r.slot] = r.raw_len;
					if ({32'b0, r.raw_offset} + {32'b0, r.raw_len} > {32'b0, file_size})
						res.status = STATUS_PAST_END;
				end
			end else begin
				translates_done++;
				a = {32'b0, r.query_addr};
				l = {32'b0, r.query_len};
				if (a < {32'b0, header_size}) begin
					// The header region maps one to one but must fit both bounds.
					if (a + l > {32'b0, header_size} || a + l > {32'b0, file_size})
						res.status = STATUS_UNMAPPED;
					else
						res.file_offset = r.query_addr;
				end else begin
					// The first section whose virtual range holds the whole
					// request decides; its zero-filled tail is not mapped.
					res.status = STATUS_UNMAPPED;
					hit = 1'b0;
					n = (int'(section_count) > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_count);
					for (int i = 0; i < n && !hit; i++) begin
						base = {32'b0, sec_start[i]};
						if (a >= base && a + l <= base + {32'b0, sec_span[i]}) begin
							hit = 1'b1;
							sec_pos = a - base;
							if (sec_pos < {32'b0, sec_length[i]} &&
									sec_pos + l <= {32'b0, sec_length[i]} &&
									{32'b0, sec_offset[i]} + sec_pos + l <= {32'b0, file_size}) begin
								res.status = STATUS_OK;
								base = {32'b0, sec_offset[i]} + sec_pos;
								res.file_offset = base[31:0];
							end
						end
					end
				end
			end
			pending_results.push_back(res);
		endfunction

		// Compares one response transfer with the oldest expectation.
		function void check_result(logic [1:0] status, logic [31:0] file_offset);
			xlat_result_t exp_res;
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding: status %0d, file_offset 0x%08h",
					status, file_offset);
				mismatches++;
				return;
			end
			exp_res = pending_results.pop_front();
			status_seen[exp_res.status]++;
			if (status !== exp_res.status) begin
				$error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
				mismatches++;
			end
			if (file_offset !== exp_res.file_offset) begin
				$error("file_offset mismatch: expected 0x%08h, actual 0x%08h",
					exp_res.file_offset, file_offset);
				mismatches++;
			end
		endfunction
	endclass

endpackage

FILE: tb/tb_section_table_address_translator.sv
// ----------------------------------------------------------------------------
// Section table address translator testbench
// Loads section tables under a range of header, file size and count
// settings, then sends translate requests aimed at section edges, the header
// region and random addresses. Every response is checked against a predictor
// held in the scoreboard, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_section_table_address_translator;
	timeunit 1ns;
	timeprecision 1ps;

	import stat_pkg::*;
	import xlat_tb_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_TARGET = 1100;
	localparam int DRAIN_CYCLES = 60;
	localparam int SENDER = 0;
	localparam int RECEIVER = 1;

	logic clk;
	logic arst_n;

	stat_req_if req();
	stat_rsp_if rsp();
	stat_cfg_if cfg();

	section_table_address_translator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	xlat_scoreboard xlat_sb = new();

	int unsigned idle_cycles = 0;
	int unsigned hold_off_cycles = 0;
	int unsigned holds_done = 0;
	int unsigned quiet_run[2] = '{0, 0};
	int unsigned requests_sent = 0;
	int unsigned settings_loaded = 0;

	// Layout of the section table currently loaded, used to aim translates.
	logic [31:0] p_virt_start[MAX_SECTIONS];
	logic [31:0] p_virt_field[MAX_SECTIONS];
	logic [31:0] p_span[MAX_SECTIONS];
	logic [31:0] p_raw_offset[MAX_SECTIONS];
	logic [31:0] p_raw_len[MAX_SECTIONS];

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// Number of cycles one side waits before its next transfer, with
	// occasional runs of back-to-back transfers.
	function automatic int unsigned draw_wait(int side);
		if (quiet_run[side] > 0) begin
			quiet_run[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			quiet_run[side] = $urandom_range(8, 40);
		return $urandom_range(0, 11);
	endfunction

	function automatic xlat_req_t make_write(logic [4:0] slot, logic [31:0] vstart,
			logic [31:0] vsize, logic [31:0] roff, logic [31:0] rlen);
		xlat_req_t r;
		r.kind = REQ_WRITE;
		r.slot = slot;
		r.virt_start = vstart;
		r.virt_size = vsize;
		r.raw_offset = roff;
		r.raw_len = rlen;
		r.query_addr = $urandom;
		r.query_len = $urandom;
		return r;
	endfunction

	function automatic xlat_req_t make_translate(logic [31:0] addr, logic [31:0] len);
		xlat_req_t r;
		r.kind = REQ_TRANSLATE;
		r.slot = 5'($urandom);
		r.virt_start = $urandom;
		r.virt_size = $urandom;
		r.raw_offset = $urandom;
		r.raw_len = $urandom;
		r.query_addr = addr;
		r.query_len = len;
		return r;
	endfunction

	// Offers one request and waits for its transfer.
	task automatic send_request(xlat_req_t r);
		int unsigned gap;
		gap = draw_wait(SENDER);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.entry_index <= r.slot;
		req.virt_start <= r.virt_start;
		req.virt_size <= r.virt_size;
		req.raw_offset <= r.raw_offset;
		req.raw_len <= r.raw_len;
		req.query_addr <= r.query_addr;
		req.query_len <= r.query_len;
		do @(posedge clk); while (!req.ready);
		xlat_sb.note_request(r);
		requests_sent++;
	endtask

	// Stops offering and waits until every outstanding response has arrived.
	task automatic wait_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (xlat_sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		xlat_sb.set_register(idx, data);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Registers are only written once the block has gone idle.
	task automatic load_settings(logic [31:0] hdr, logic [31:0] fsz, logic [31:0] cnt_word);
		wait_drained();
		write_register(CFG_HEADER_SIZE, hdr);
		write_register(CFG_FILE_SIZE, fsz);
		write_register(CFG_SECTION_COUNT, cnt_word);
		settings_loaded++;
	endtask

	// Response side: random stalls, plus a long hold-off when asked for.
	initial begin : response_sink
		int unsigned stall;
		rsp.ready = 1'b0;
		forever begin
			stall = draw_wait(RECEIVER);
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
				holds_done++;
			end
			@(negedge clk);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			xlat_sb.check_result(rsp.status, rsp.file_offset);
		end
	end

	// Stimulus.
	initial begin : stimulus
		logic [63:0] vcur;
		logic [63:0] rcur;
		logic [63:0] off64;
		logic [31:0] hdr;
		logic [31:0] fsz;
		logic [31:0] noise;
		logic [31:0] scale;
		logic [31:0] addr;
		logic [31:0] len;
		logic [5:0]  cnt;
		int          eff;
		int          s;
		int          pick;
		int          n_probe;
		int          hold_at;

		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_WRITE;
		req.entry_index = '0;
		req.virt_start = '0;
		req.virt_size = '0;
		req.raw_offset = '0;
		req.raw_len = '0;
		req.query_addr = '0;
		req.query_len = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_HEADER_SIZE;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Settings after reset are all zero: nothing is mapped, and any
		// non-empty raw range lies past the file end.
		send_request(make_translate(32'h0, 32'h0));
		send_request(make_translate(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_request(make_write(5'd0, 32'h0, 32'h0, 32'h0, 32'h0));
		send_request(make_write(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));

		// A small image: a section with a zero-filled tail, one whose virtual
		// size comes from its raw size, and one whose data passes the file end.
		load_settings(32'h400, 32'h1_0000, 32'd3);
		send_request(make_write(5'd0, 32'h1000, 32'h2000, 32'h400, 32'h1000));
		send_request(make_write(5'd1, 32'h3000, 32'h0, 32'h1400, 32'h800));
		send_request(make_write(5'd2, 32'h4000, 32'h1000, 32'hFF00, 32'h200));
		send_request(make_translate(32'h10, 32'h10));
		send_request(make_translate(32'h3F0, 32'h20));
		send_request(make_translate(32'h1000, 32'h4));
		send_request(make_translate(32'h1FFC, 32'h4));
		send_request(make_translate(32'h1FFE, 32'h4));
		send_request(make_translate(32'h2800, 32'h1));
		send_request(make_translate(32'h3000, 32'h800));
		send_request(make_translate(32'h37FF, 32'h2));
		send_request(make_translate(32'h4000, 32'h100));
		send_request(make_translate(32'h40F0, 32'h20));
		send_request(make_translate(32'h8000, 32'h1));

		// Header region larger than the file.
		load_settings(32'hFFFF_FFFF, 32'h100, 32'd3);
		send_request(make_translate(32'h80, 32'h80));
		send_request(make_translate(32'h80, 32'h81));
		send_request(make_translate(32'hFFFF_FFFE, 32'h1));
		send_request(make_translate(32'hFFFF_FFFF, 32'h0));

		// Random phases: load a fresh table, then probe it.
		while (requests_sent < ITEM_TARGET) begin
			scale = ($urandom_range(0, 3) == 0) ? 32'h0100_0000 : 32'h0000_0400;
			case ($urandom_range(0, 9))
				0: cnt = 6'd0;
				1: cnt = 6'd32;
				2: cnt = ($urandom_range(0, 1) == 0) ? 6'd63 : 6'($urandom_range(33, 62));
				3: cnt = 6'($urandom_range(9, 31));
				default: cnt = 6'($urandom_range(1, 8));
			endcase
			eff = (int'(cnt) > MAX_SECTIONS) ? MAX_SECTIONS : int'(cnt);
			case ($urandom_range(0, 9))
				0: hdr = 32'h0;
				1: hdr = 32'hFFFF_FFFF;
				2: hdr = $urandom;
				default: hdr = $urandom_range(1, scale);
			endcase

			// Lay the sections out one after another, with some overlap and
			// some fully random entries.
			vcur = {32'b0, hdr} + $urandom_range(0, scale);
			rcur = $urandom_range(0, scale);
			for (int k = 0; k < eff; k++) begin
				p_raw_len[k] = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom_range(1, scale);
				case ($urandom_range(0, 9))
					0: p_virt_field[k] = 32'h0;
					1: p_virt_field[k] = p_raw_len[k];
					2, 3: p_virt_field[k] = p_raw_len[k] + $urandom_range(1, scale);
					4: p_virt_field[k] = p_raw_len[k] >> 1;
					5: p_virt_field[k] = $urandom;
					default: p_virt_field[k] = p_raw_len[k] + $urandom_range(0, scale / 4);
				endcase
				p_span[k] = (p_virt_field[k] != 0) ? p_virt_field[k] : p_raw_len[k];
				pick = $urandom_range(0, 15);
				if (pick == 0)
					p_virt_start[k] = $urandom;
				else if (pick < 3 && k > 0)
					p_virt_start[k] = p_virt_start[k - 1];
				else
					p_virt_start[k] = vcur[31:0];
				p_raw_offset[k] = ($urandom_range(0, 15) == 0) ? $urandom : rcur[31:0];
				vcur = vcur + p_span[k] + $urandom_range(0, scale / 8);
				rcur = rcur + p_raw_len[k];
				if ($urandom_range(0, 3) == 0)
					rcur = rcur + $urandom_range(0, 64);
			end
			case ($urandom_range(0, 9))
				0: fsz = rcur[31:0] - $urandom_range(1, scale);
				1: fsz = 32'hFFFF_FFFF;
				2: fsz = 32'h0;
				3: fsz = $urandom;
				4, 5: fsz = rcur[31:0];
				default: fsz = rcur[31:0] + $urandom_range(0, scale);
			endcase
			noise = $urandom;
			if ($urandom_range(0, 3) != 0)
				noise = '0;
			load_settings(hdr, fsz, {noise[31:6], cnt});

			// Every searched slot is loaded before any translate can reach it.
			for (int k = 0; k < eff; k++)
				send_request(make_write(5'(k), p_virt_start[k], p_virt_field[k],
					p_raw_offset[k], p_raw_len[k]));

			hold_at = (settings_loaded == 4 || $urandom_range(0, 7) == 0) ?
				$urandom_range(0, 20) : -1;
			n_probe = $urandom_range(30, 70);
			for (int i = 0; i < n_probe; i++) begin
				if (i == hold_at)
					hold_off_cycles = $urandom_range(100, 200);
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					// Overwrite a random slot with random content.
					s = $urandom_range(0, MAX_SECTIONS - 1);
					p_virt_start[s] = $urandom;
					p_virt_field[s] = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
					p_raw_offset[s] = $urandom;
					p_raw_len[s] = $urandom;
					p_span[s] = (p_virt_field[s] != 0) ? p_virt_field[s] : p_raw_len[s];
					send_request(make_write(5'(s), p_virt_start[s], p_virt_field[s],
						p_raw_offset[s], p_raw_len[s]));
				end else begin
					if (pick < 20 && hdr != 0) begin
						// Header region, with the end near either bound.
						addr = $urandom_range(0, hdr - 1);
						case ($urandom_range(0, 4))
							0: len = hdr - addr;
							1: len = hdr - addr + 1;
							2: len = fsz - addr;
							3: len = fsz - addr + 1;
							default: len = $urandom_range(0, 64);
						endcase
					end else if (pick < 30 || eff == 0) begin
						addr = ($urandom_range(0, 1) == 0) ? $urandom : hdr + $urandom_range(0, scale);
						len = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 256);
					end else begin
						// Aim at a loaded section, around its raw and virtual ends.
						s = $urandom_range(0, eff - 1);
						case ($urandom_range(0, 5))
							0: len = 32'h0;
							1: len = 32'h1;
							2: len = p_raw_len[s];
							3: len = $urandom;
							default: len = $urandom_range(1, 64);
						endcase
						case ($urandom_range(0, 7))
							0: off64 = 64'h0;
							1: off64 = {32'b0, p_raw_len[s]} - len;
							2: off64 = {32'b0, p_raw_len[s]} - len + 1;
							3: off64 = {32'b0, p_span[s]} - len;
							4: off64 = {32'b0, p_span[s]} - len + 1;
							5: off64 = {32'b0, p_raw_len[s]};
							default: off64 = $urandom_range(0, p_span[s]);
						endcase
						addr = p_virt_start[s] + off64[31:0];
					end
					send_request(make_translate(addr, len));
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests (%0d section writes, %0d translates) under %0d settings.",
			requests_sent, xlat_sb.writes_done, xlat_sb.translates_done, settings_loaded);
		$display("Responses: %0d ok, %0d not mapped, %0d past file end; %0d long hold-offs.",
			xlat_sb.status_seen[STATUS_OK], xlat_sb.status_seen[STATUS_UNMAPPED],
			xlat_sb.status_seen[STATUS_PAST_END], holds_done);
		if (xlat_sb.mismatches == 0 && xlat_sb.pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/stat_pkg.sv
hdl/stat_req_if.sv
hdl/stat_rsp_if.sv
hdl/stat_cfg_if.sv
hdl/section_table_address_translator.sv
tb/xlat_tb_pkg.sv
tb/tb_section_table_address_translator.sv
